// ----- design/hasp_pkg.sv -----
`default_nettype none

package hasp_pkg;

  localparam logic [7:0] COLON_CHAR = 8'h3A;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_F  = 8'h66;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_F  = 8'h46;

  localparam logic [4:0] MAX_DIGITS = 5'd16;
  localparam logic [4:0] DIGIT_SAT  = 5'd17;

  localparam logic [1:0] FIELD_ADDR = 2'd0;
  localparam logic [1:0] FIELD_SIZE = 2'd1;
  localparam logic [1:0] FIELD_REST = 2'd2;

  typedef struct packed {
    logic       is_colon;
    logic       is_hex;
    logic [3:0] digit;
  } char_class_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] address;
    logic [63:0] window_size;
  } result_t;

endpackage

`default_nettype wire

// ----- design/hasp_decode.sv -----
`default_nettype none

module hasp_decode (
  input  wire logic [7:0]           char_code,
  output hasp_pkg::char_class_t     cls
);
  import hasp_pkg::*;

  logic [7:0] off_num;
  logic [7:0] off_lc;
  logic [7:0] off_uc;

  assign off_num = char_code - CHAR_0;
  assign off_lc  = char_code - CHAR_LC_A + 8'd10;
  assign off_uc  = char_code - CHAR_UC_A + 8'd10;

  always_comb begin
    cls.is_colon = (char_code == COLON_CHAR);
    cls.is_hex   = 1'b1;
    cls.digit    = 4'd0;
    priority if (char_code >= CHAR_0 && char_code <= CHAR_9) begin
      cls.digit = off_num[3:0];
    end else if (char_code >= CHAR_LC_A && char_code <= CHAR_LC_F) begin
      cls.digit = off_lc[3:0];
    end else if (char_code >= CHAR_UC_A && char_code <= CHAR_UC_F) begin
      cls.digit = off_uc[3:0];
    end else begin
      cls.is_hex = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- design/hasp_core.sv -----
`default_nettype none

module hasp_core #(
  parameter int MAX_LEN = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire logic [7:0]        char_code,
  input  wire logic              has_char,
  input  wire logic              last,
  output hasp_pkg::result_t      result
);
  import hasp_pkg::*;

  localparam int LenW = $clog2(MAX_LEN + 2);
  localparam logic [LenW-1:0] LenMax = LenW'(MAX_LEN);

  char_class_t cls;

  logic [1:0]      field_index, field_index_next;
  logic [4:0]      digit_count, digit_count_next;
  logic [63:0]     address_acc, address_acc_next;
  logic [63:0]     size_acc, size_acc_next;
  logic            error_flag, error_flag_next;
  logic [LenW-1:0] length_count, length_count_next;
  logic            ok;

  hasp_decode u_decode (
    .char_code (char_code),
    .cls       (cls)
  );

  always_comb begin
    field_index_next  = field_index;
    digit_count_next  = digit_count;
    address_acc_next  = address_acc;
    size_acc_next     = size_acc;
    error_flag_next   = error_flag;
    length_count_next = length_count;
    if (has_char) begin
      if (length_count <= LenMax) begin
        length_count_next = length_count + 1'b1;
      end
      if (field_index != FIELD_REST) begin
        priority if (cls.is_colon) begin
          if (digit_count == 5'd0) begin
            error_flag_next = 1'b1;
          end
          field_index_next = field_index + 2'd1;
          digit_count_next = 5'd0;
        end else if (!cls.is_hex) begin
          error_flag_next = 1'b1;
        end else if (digit_count >= MAX_DIGITS) begin
          error_flag_next  = 1'b1;
          digit_count_next = DIGIT_SAT;
        end else begin
          digit_count_next = digit_count + 5'd1;
          if (field_index == FIELD_ADDR) begin
            address_acc_next = {address_acc[59:0], cls.digit};
          end else begin
            size_acc_next = {size_acc[59:0], cls.digit};
          end
        end
      end
    end
  end

  assign ok = !error_flag_next && (field_index_next == FIELD_REST) &&
              (length_count_next != '0) && (length_count_next <= LenMax);

  always_comb begin
    result.ok          = ok;
    result.address     = ok ? address_acc_next : 64'd0;
    result.window_size = ok ? size_acc_next : 64'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last)) begin
      field_index  <= FIELD_ADDR;
      digit_count  <= 5'd0;
      address_acc  <= 64'd0;
      size_acc     <= 64'd0;
      error_flag   <= 1'b0;
      length_count <= '0;
    end else if (take) begin
      field_index  <= field_index_next;
      digit_count  <= digit_count_next;
      address_acc  <= address_acc_next;
      size_acc     <= size_acc_next;
      error_flag   <= error_flag_next;
      length_count <= length_count_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/hex_address_size_token_parser_top.sv -----
`default_nettype none

// channel  | handshake                      | payload
// ---------+--------------------------------+------------------------------------------
// input    | in_valid in, in_stall out      | char_code[7:0], has_char, last
// output   | out_valid out, out_stall in    | valid_res, address[63:0], window_size[63:0]
//
// one character transaction is taken every cycle while in_stall is low; the parse state
// updates at the accepting edge, where the result of a token's last character goes into
// the output slot, or into the skid entry while the output slot is held. a result register
// plus one skid entry part the two channels, so in_stall rises only when the skid entry is
// full. rst is synchronous, clears the parse state and empties both result slots.

module hex_address_size_token_parser_top #(
  parameter int MAX_LEN = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_code,
  input  wire logic        has_char,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             valid_res,
  output logic [63:0]      address,
  output logic [63:0]      window_size
);
  import hasp_pkg::*;

  logic    take;
  logic    produce;
  logic    out_take;
  result_t core_result;

  // output slot and skid slot
  result_t out_data;
  result_t skid_data;
  logic    skid_valid;

  assign in_stall = skid_valid;
  assign take     = in_valid && !in_stall;
  assign produce  = take && last;
  assign out_take = out_valid && !out_stall;

  hasp_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_code (char_code),
    .has_char  (has_char),
    .last      (last),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // input is stalled, only drain the skid into the output slot
      if (out_take) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (produce) begin
      if (!out_valid || out_take) begin
        out_data  <= core_result;
        out_valid <= 1'b1;
      end else begin
        // output slot still held downstream, park the new result
        skid_data  <= core_result;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  assign valid_res   = out_data.ok;
  assign address     = out_data.address;
  assign window_size = out_data.window_size;

endmodule

`default_nettype wire

// ----- bench/hex_address_size_token_parser_top_tb.sv -----
module hex_address_size_token_parser_top_tb;
  import hasp_pkg::*;

  localparam int TOKEN_MAX   = 64;    // length limit given to the block
  localparam int ITEM_GOAL   = 1450;  // characters to send before stopping
  localparam int QUIET_FROM  = 1250;  // no idling on either side after this
  localparam int IDLE_LIMIT  = 2000;  // cycles with no transaction before giving up
  localparam int DRAIN_WAIT  = 8;     // settle time after the last result

  localparam result_t BAD_RES = '{1'b0, 64'h0, 64'h0};

  // random token shapes
  typedef enum int {
    TK_GOOD,
    TK_WIDE_FIELD,
    TK_CORRUPT,
    TK_NO_COLON,
    TK_OVERLONG,
    TK_NOISE
  } token_kind_t;

  // one row of the directed table: a whole token plus how to send it
  typedef struct {
    string   text;       // characters of the token
    int      pad;        // random bytes appended after the text
    bit      blank_mid;  // an ignored empty item after the first character
    bit      empty_end;  // close with an empty final item
    bit      known;      // res below is the expected result
    result_t res;
  } token_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = 8'h00;
  logic        has_char = 1'b0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        valid_res;
  logic [63:0] address;
  logic [63:0] window_size;

  hex_address_size_token_parser_top #(
    .MAX_LEN(TOKEN_MAX)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .char_code(char_code),
    .has_char(has_char),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .valid_res(valid_res),
    .address(address),
    .window_size(window_size)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parse state of the predictor
  logic [1:0]  cur_field = FIELD_ADDR;
  logic [4:0]  digit_cnt = '0;
  logic [63:0] addr_acc = '0;
  logic [63:0] size_acc = '0;
  bit          field_err = 1'b0;
  int          tok_len = 0;

  result_t     parsed_results [$];  // results still owed by the block
  bit          typed_on = 1'b0;     // directed row with a typed-in result
  result_t     typed_res = BAD_RES;

  bit          quiet = 1'b0;
  int          n_chars = 0;
  int          n_tokens = 0;
  int          n_results = 0;
  int          n_valid = 0;
  int          n_bad = 0;
  int          idle_cycles = 0;

  token_row_t  dir_tab [18];

  // hex value of an ascii byte, -1 when it is no hex digit
  function automatic int nibble_of(logic [7:0] c);
    if (c >= CHAR_0 && c <= CHAR_9) return int'(c - CHAR_0);
    if (c >= CHAR_LC_A && c <= CHAR_LC_F) return int'(c - CHAR_LC_A) + 10;
    if (c >= CHAR_UC_A && c <= CHAR_UC_F) return int'(c - CHAR_UC_A) + 10;
    return -1;
  endfunction

  // ascii digit for a nibble, letters in random case
  function automatic logic [7:0] hex_char(int v);
    if (v < 10) return CHAR_0 + 8'(v);
    return (($urandom_range(0, 1) == 0) ? CHAR_LC_A : CHAR_UC_A) + 8'(v - 10);
  endfunction

  // advance the parse by one accepted transaction; got is set on a token end
  task automatic parse_step(input logic [7:0] c, input logic h, input logic l,
                            output bit got, output result_t r);
    int d;
    bit ok;
    got = 1'b0;
    r = BAD_RES;
    if (h) begin
      if (tok_len <= TOKEN_MAX) tok_len++;
      // everything past the second colon only counts toward the length
      if (cur_field < FIELD_REST) begin
        if (c == COLON_CHAR) begin
          // a colon closing an empty field spoils the token
          if (digit_cnt == 0) field_err = 1'b1;
          cur_field = cur_field + 2'd1;
          digit_cnt = '0;
        end else begin
          d = nibble_of(c);
          if (d < 0) begin
            field_err = 1'b1;
          end else if (digit_cnt >= MAX_DIGITS) begin
            // seventeenth digit: too wide, count saturates
            field_err = 1'b1;
            digit_cnt = DIGIT_SAT;
          end else begin
            digit_cnt = digit_cnt + 5'd1;
            if (cur_field == FIELD_ADDR) addr_acc = {addr_acc[59:0], 4'(d)};
            else size_acc = {size_acc[59:0], 4'(d)};
          end
        end
      end
    end
    if (l) begin
      ok = !field_err && cur_field >= FIELD_REST && tok_len != 0 &&
           tok_len <= TOKEN_MAX;
      got = 1'b1;
      r.ok = ok;
      r.address = ok ? addr_acc : 64'h0;
      r.window_size = ok ? size_acc : 64'h0;
      // back to the start of a token
      cur_field = FIELD_ADDR;
      digit_cnt = '0;
      addr_acc = '0;
      size_acc = '0;
      field_err = 1'b0;
      tok_len = 0;
    end
  endtask

  // present one transaction, maybe after an idle burst, and wait for acceptance
  task automatic send_item(input logic [7:0] c, input logic h, input logic l);
    bit got;
    result_t r;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    has_char <= h;
    last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge
    parse_step(c, h, l, got, r);
    if (got) begin
      parsed_results.push_back(typed_on ? typed_res : r);
      n_tokens++;
    end
    if (h) n_chars++;
  endtask

  // hold the input channel idle until every owed result is out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (parsed_results.size() != 0) @(posedge clk);
  endtask

  // build one random token, mostly well formed, and send it
  task automatic random_token();
    logic [7:0]  tok [$];
    token_kind_t kind;
    int          pick;
    int          na;
    int          ns;
    int          nr;
    int          pos;
    bit          blank_end;
    pick = $urandom_range(0, 99);
    kind = pick < 68 ? TK_GOOD : pick < 76 ? TK_WIDE_FIELD : pick < 84 ? TK_CORRUPT :
           pick < 90 ? TK_NO_COLON : pick < 95 ? TK_OVERLONG : TK_NOISE;
    // full sixteen digit fields come up often enough to matter
    na = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 16);
    ns = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 16);
    if (kind == TK_WIDE_FIELD) begin
      if ($urandom_range(0, 1) == 0) na = $urandom_range(17, 19);
      else ns = $urandom_range(17, 19);
    end
    nr = $urandom_range(0, 10);
    // rest long enough to land around the length limit
    if (kind == TK_OVERLONG) nr = $urandom_range(60, 70) - na - ns - 2;
    if (kind == TK_NOISE) begin
      repeat ($urandom_range(0, 8)) tok.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat (na) tok.push_back(hex_char($urandom_range(0, 15)));
      tok.push_back(COLON_CHAR);
      repeat (ns) tok.push_back(hex_char($urandom_range(0, 15)));
      tok.push_back(COLON_CHAR);
      // rest: any byte, extra colons included
      repeat (nr) begin
        tok.push_back(($urandom_range(0, 5) == 0) ? COLON_CHAR :
                      8'($urandom_range(0, 255)));
      end
      if (kind == TK_CORRUPT) begin
        pos = $urandom_range(0, na + ns);
        tok[pos] = 8'($urandom_range(0, 255));
      end
      if (kind == TK_NO_COLON) begin
        // cut the token at one of its two colons
        pos = ($urandom_range(0, 1) == 0) ? na : na + ns + 1;
        while (tok.size() > pos) void'(tok.pop_back());
      end
    end
    blank_end = (tok.size() == 0) || ($urandom_range(0, 7) == 0);
    foreach (tok[k]) begin
      // ignored empty transactions sprinkled in
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(tok[k], 1'b1, (k == tok.size() - 1) && !blank_end);
    end
    if (blank_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic report_bad(input string what);
    n_bad++;
    if (n_bad <= 10) $display("mismatch at result %0d: %s", n_results, what);
  endtask

  // result checker: every accepted result against the oldest owed one
  result_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (valid_res) n_valid++;
      if (parsed_results.size() == 0) begin
        report_bad("result with no token pending");
      end else begin
        want = parsed_results.pop_front();
        if (valid_res !== want.ok || address !== want.address ||
            window_size !== want.window_size) begin
          report_bad($sformatf("expected ok=%0b addr=%h size=%h, got ok=%0b addr=%h size=%h",
                               want.ok, want.address, want.window_size,
                               valid_res, address, window_size));
        end
      end
    end
  end

  // watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results owed",
                 idle_cycles, parsed_results.size());
        $display("hex_address_size_token_parser_top_tb NOT OK");
        $finish;
      end
    end
  end

  // receiver back-pressure in bursts, none in the quiet tail
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        if (!quiet) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 19)) @(posedge clk);
        end
      end
    end
  end

  // main sequence: reset, directed tokens, random tokens, drain
  initial begin
    token_row_t row;
    int         n;
    logic [7:0] c;
    bit         paused;
    paused = 1'b0;
    dir_tab = '{
      // empty token right after reset
      '{"", 0, 1'b0, 1'b1, 1'b1, BAD_RES},
      // smallest and largest well formed fields
      '{"0:0:", 0, 1'b0, 1'b0, 1'b1, '{1'b1, 64'h0, 64'h0}},
      '{"ffffffffffffffff:FFFFFFFFFFFFFFFF:", 0, 1'b0, 1'b0, 1'b1,
        '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}},
      '{"0123456789abcdef:ABCDEF:", 0, 1'b0, 1'b0, 1'b0, BAD_RES},
      // seventeen digits in either field
      '{"12345678123456789:1:", 0, 1'b0, 1'b0, 1'b1, BAD_RES},
      '{"1:12345678123456789:", 0, 1'b0, 1'b0, 1'b1, BAD_RES},
      // empty address, empty size
      '{":5:", 0, 1'b0, 1'b0, 1'b1, BAD_RES},
      '{"5::", 0, 1'b0, 1'b0, 1'b1, BAD_RES},
      // missing first and second colon
      '{"5", 0, 1'b0, 1'b0, 1'b1, BAD_RES},
      '{"5:6", 0, 1'b0, 1'b0, 1'b1, BAD_RES},
      // bytes just outside the digit ranges
      '{"/@`:1:", 0, 1'b0, 1'b0, 1'b1, BAD_RES},
      '{"1:9G:", 0, 1'b0, 1'b0, 1'b1, BAD_RES},
      '{"a:-3:", 0, 1'b0, 1'b0, 1'b1, BAD_RES},
      // colons in the rest are ignored
      '{"7f:80:x:y::", 0, 1'b0, 1'b0, 1'b0, BAD_RES},
      // exactly at the length limit, then one over
      '{"1:2:", 60, 1'b0, 1'b0, 1'b0, BAD_RES},
      '{"1:2:", 61, 1'b0, 1'b0, 1'b1, BAD_RES},
      // ignored empty transaction inside a token
      '{"Fa:0B:", 0, 1'b1, 1'b0, 1'b0, BAD_RES},
      // token closed by an empty final transaction
      '{"3:4:", 0, 1'b0, 1'b1, 1'b0, BAD_RES}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      row = dir_tab[i];
      n = row.text.len() + row.pad;
      typed_on = row.known;
      typed_res = row.res;
      for (int k = 0; k < n; k++) begin
        c = (k < row.text.len()) ? row.text[k] : 8'($urandom_range(0, 255));
        if (row.blank_mid && k == 1) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_item(c, 1'b1, (k == n - 1) && !row.empty_end);
      end
      if (row.empty_end || n == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      typed_on = 1'b0;
    end
    drain_results();

    while (n_chars < ITEM_GOAL) begin
      if (n_chars >= QUIET_FROM) quiet = 1'b1;
      // one full stop of the sender halfway through
      if (!paused && n_chars >= ITEM_GOAL / 2) begin
        drain_results();
        paused = 1'b1;
      end
      random_token();
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d tokens from %0d characters: %0d results, %0d of them valid",
             n_tokens, n_chars, n_results, n_valid);
    $display("%0d mismatches, %0d results still owed", n_bad, parsed_results.size());
    if (n_bad == 0 && parsed_results.size() == 0) begin
      $display("hex_address_size_token_parser_top_tb OK");
    end else begin
      $display("hex_address_size_token_parser_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- hex_address_size_token_parser_top.f -----
design/hasp_pkg.sv
design/hasp_decode.sv
design/hasp_core.sv
design/hex_address_size_token_parser_top.sv
bench/hex_address_size_token_parser_top_tb.sv
